// ===== rtl/core/r250_pkg.sv =====
// ----------------------------------------------------------------------------
// r250_pkg
// Shared types, constants and helpers of the R250 random generator.
// ----------------------------------------------------------------------------
`default_nettype none

package r250_pkg;

    localparam int RING_LEN = 250;
    localparam int RING_AW  = 8;
    localparam int DIAG_LEN = 32;

    typedef logic [31:0]        t_word;
    typedef logic [RING_AW-1:0] t_ring_addr;
    typedef logic [1:0]         t_cmd;

    localparam t_ring_addr RING_LAST = 8'd249;
    localparam t_ring_addr RING_WRAP = 8'd147;
    localparam t_ring_addr RING_TAP  = 8'd103;

    localparam logic [14:0] LEHMER_MUL = 15'd16807;
    localparam t_word       LEHMER_MOD = 32'h7fff_ffff;

    localparam t_word WORD_TOP  = 32'h8000_0000;
    localparam t_word WORD_ONES = 32'hffff_ffff;

    localparam t_cmd CMD_RAW     = 2'd0;
    localparam t_cmd CMD_BOUNDED = 2'd1;
    localparam t_cmd CMD_RESEED  = 2'd2;

    typedef struct packed {
        logic       rd_en;
        t_ring_addr rd_addr_a;
        t_ring_addr rd_addr_b;
        logic       wr_en;
        t_ring_addr wr_addr;
        t_word      wr_data;
    } t_ring_req;

    // Force the diagonal word at 5j+3: clear bits above 31-j, set bit 31-j.
    function automatic t_word diag_force(input t_ring_addr idx, input t_word w);
        t_word res;
        res = w;
        for (int j = 0; j < DIAG_LEN; j++) begin
            if (idx == RING_AW'(5 * j + 3)) begin
                res = (w & (WORD_ONES >> j)) | (WORD_TOP >> j);
            end
        end
        return res;
    endfunction

    // Ring contents after a reseed with seed zero.
    function automatic t_word ring_reset_word(input t_ring_addr idx);
        return diag_force(idx, '0);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/r250_ring.sv =====
// ----------------------------------------------------------------------------
// r250_ring
// Ring word memory: two registered read ports, one write port. Entries not
// yet written read as the seed-zero contents.
// ----------------------------------------------------------------------------
`default_nettype none

module r250_ring (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire r250_pkg::t_ring_req i_req,
    output r250_pkg::t_word         o_rd_a,
    output r250_pkg::t_word         o_rd_b
);

    r250_pkg::t_word     r_mem [r250_pkg::RING_LEN];
    logic [r250_pkg::RING_LEN-1:0] r_valid;

    r250_pkg::t_word     r_rd_a;
    r250_pkg::t_word     r_rd_b;
    logic                r_va;
    logic                r_vb;
    r250_pkg::t_ring_addr r_addr_a;
    r250_pkg::t_ring_addr r_addr_b;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_a   <= r_mem[i_req.rd_addr_a];
            r_rd_b   <= r_mem[i_req.rd_addr_b];
            r_va     <= r_valid[i_req.rd_addr_a];
            r_vb     <= r_valid[i_req.rd_addr_b];
            r_addr_a <= i_req.rd_addr_a;
            r_addr_b <= i_req.rd_addr_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_a = r_va ? r_rd_a : r250_pkg::ring_reset_word(r_addr_a);
    assign o_rd_b = r_vb ? r_rd_b : r250_pkg::ring_reset_word(r_addr_b);

endmodule

`default_nettype wire

// ===== rtl/core/r250_lehmer.sv =====
// ----------------------------------------------------------------------------
// r250_lehmer
// Minimal-standard Lehmer step unit: multiply by 16807, then fold modulo
// 2^31-1. A step registers the product, then the folded state.
// ----------------------------------------------------------------------------
`default_nettype none

module r250_lehmer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire r250_pkg::t_word i_load_value,
    input  wire logic            i_step,
    output r250_pkg::t_word      o_state
);

    r250_pkg::t_word r_state;
    logic            r_mul_valid;
    logic [46:0]     r_prod;

    logic [31:0]     fold_sum;
    r250_pkg::t_word fold_res;

    always_comb begin
        fold_sum = {1'b0, r_prod[30:0]} + {16'b0, r_prod[46:31]};
        fold_res = (fold_sum >= r250_pkg::LEHMER_MOD) ?
                   fold_sum - r250_pkg::LEHMER_MOD : fold_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_prod <= 47'(r_state) * 47'(r250_pkg::LEHMER_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_mul_valid <= 1'b0;
        end else begin
            r_mul_valid <= i_step;
            if (i_load) begin
                r_state <= i_load_value;
            end else if (r_mul_valid) begin
                r_state <= fold_res;
            end
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ===== rtl/core/r250_random_generator_unit.sv =====
// ----------------------------------------------------------------------------
// r250_random_generator_unit
// R250 shift-register random generator with bounded draws and reseeding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries i_cmd and i_limit: raw draw,
//   bounded draw below i_limit, or reseed from the seed register. Each beat
//   yields exactly one result beat on o_out_valid/i_out_ready: o_value and
//   o_bad_limit (set for a bounded draw with a zero limit).
//   Seed port (i_cfg_valid/o_cfg_ready) writes the seed; it is always ready.
//   A raw draw reads both taps from the ring memory at once, then writes
//   back. A bounded draw repeats this for each redraw, while the masked
//   value is not below the limit. A reseed loads the seed in the accept
//   cycle, then builds each of the 250 words from two Lehmer steps.
//   Zero-limit and unused commands answer in the accept cycle.
//   One item is worked on at a time; the next is accepted once the result
//   sits in the output register, even while the receiver stalls. If the
//   output register is still full when a result finishes, the result waits
//   in a holding register and input stays blocked.
//   Reset loads the seed-zero state at once: seed 0, pointer 0, ring as
//   reseeded with zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module r250_random_generator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_limit,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_value,
    output logic             o_bad_limit,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_seed_value
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DRAW = 3'd1;
    localparam logic [2:0] ST_SMA  = 3'd2;
    localparam logic [2:0] ST_SFA  = 3'd3;
    localparam logic [2:0] ST_SMB  = 3'd4;
    localparam logic [2:0] ST_SFB  = 3'd5;
    localparam logic [2:0] ST_SWR  = 3'd6;
    localparam logic [2:0] ST_PUSH = 3'd7;

    logic [2:0]           r_state, n_state;
    r250_pkg::t_ring_addr r_ptr, n_ptr;
    r250_pkg::t_ring_addr r_widx, n_widx;
    r250_pkg::t_word      r_first, n_first;
    r250_pkg::t_word      r_mask, n_mask;
    r250_pkg::t_word      r_limit, n_limit;
    logic                 r_bounded, n_bounded;
    r250_pkg::t_word      r_seed, n_seed;
    logic                 r_out_valid, n_out_valid;
    r250_pkg::t_word      r_out_value, n_out_value;
    logic                 r_out_bad, n_out_bad;
    r250_pkg::t_word      r_res_value, n_res_value;
    logic                 r_res_bad, n_res_bad;

    r250_pkg::t_ring_req  ring_req;
    r250_pkg::t_word      rd_a;
    r250_pkg::t_word      rd_b;
    logic                 lm_load;
    logic                 lm_step;
    r250_pkg::t_word      lm_state;

    r250_pkg::t_ring_addr ptr_next;
    r250_pkg::t_ring_addr tap_cur;
    r250_pkg::t_ring_addr tap_next;
    r250_pkg::t_word      draw_val;
    r250_pkg::t_word      masked;
    r250_pkg::t_word      lim_mask;
    logic                 in_acc;
    logic                 out_free;
    logic                 fin;
    r250_pkg::t_word      fin_value;
    logic                 fin_bad;

    function automatic r250_pkg::t_ring_addr tap_addr(input r250_pkg::t_ring_addr p);
        return (p >= r250_pkg::RING_WRAP) ? p - r250_pkg::RING_WRAP
                                          : p + r250_pkg::RING_TAP;
    endfunction

    r250_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ring_req),
        .o_rd_a  (rd_a),
        .o_rd_b  (rd_b)
    );

    r250_lehmer u_lehmer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (lm_load),
        .i_load_value (r_seed),
        .i_step       (lm_step),
        .o_state      (lm_state)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_bad_limit = r_out_bad;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign ptr_next = (r_ptr == r250_pkg::RING_LAST) ? '0 : r_ptr + 8'd1;
    assign tap_cur  = tap_addr(r_ptr);
    assign tap_next = tap_addr(ptr_next);
    assign draw_val = rd_a ^ rd_b;
    assign masked   = draw_val & r_mask;

    always_comb begin
        lim_mask = i_limit;
        lim_mask = lim_mask | (lim_mask >> 1);
        lim_mask = lim_mask | (lim_mask >> 2);
        lim_mask = lim_mask | (lim_mask >> 4);
        lim_mask = lim_mask | (lim_mask >> 8);
        lim_mask = lim_mask | (lim_mask >> 16);
    end

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_widx      = r_widx;
        n_first     = r_first;
        n_mask      = r_mask;
        n_limit     = r_limit;
        n_bounded   = r_bounded;
        n_seed      = i_cfg_valid ? i_seed_value : r_seed;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_bad   = r_out_bad;
        n_res_value = r_res_value;
        n_res_bad   = r_res_bad;
        ring_req    = '0;
        lm_load     = 1'b0;
        lm_step     = 1'b0;
        fin         = 1'b0;
        fin_value   = '0;
        fin_bad     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_cmd)
                        r250_pkg::CMD_RAW: begin
                            ring_req.rd_en     = 1'b1;
                            ring_req.rd_addr_a = r_ptr;
                            ring_req.rd_addr_b = tap_cur;
                            n_bounded          = 1'b0;
                            n_state            = ST_DRAW;
                        end
                        r250_pkg::CMD_BOUNDED: begin
                            if (i_limit == '0) begin
                                fin     = 1'b1;
                                fin_bad = 1'b1;
                            end else begin
                                ring_req.rd_en     = 1'b1;
                                ring_req.rd_addr_a = r_ptr;
                                ring_req.rd_addr_b = tap_cur;
                                n_bounded          = 1'b1;
                                n_mask             = lim_mask;
                                n_limit            = i_limit;
                                n_state            = ST_DRAW;
                            end
                        end
                        r250_pkg::CMD_RESEED: begin
                            lm_load = 1'b1;
                            n_widx  = '0;
                            n_ptr   = '0;
                            n_state = ST_SMA;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAW: begin
                ring_req.wr_en   = 1'b1;
                ring_req.wr_addr = r_ptr;
                ring_req.wr_data = draw_val;
                n_ptr            = ptr_next;
                if (r_bounded && (masked >= r_limit)) begin
                    ring_req.rd_en     = 1'b1;
                    ring_req.rd_addr_a = ptr_next;
                    ring_req.rd_addr_b = tap_next;
                end else begin
                    fin       = 1'b1;
                    fin_value = r_bounded ? masked : draw_val;
                end
            end
            ST_SMA: begin
                lm_step = 1'b1;
                n_state = ST_SFA;
            end
            ST_SFA: begin
                n_state = ST_SMB;
            end
            ST_SMB: begin
                n_first = lm_state;
                lm_step = 1'b1;
                n_state = ST_SFB;
            end
            ST_SFB: begin
                n_state = ST_SWR;
            end
            ST_SWR: begin
                ring_req.wr_en   = 1'b1;
                ring_req.wr_addr = r_widx;
                ring_req.wr_data = r250_pkg::diag_force(r_widx,
                                       r_first ^ {lm_state[23:0], 8'h00});
                if (r_widx == r250_pkg::RING_LAST) begin
                    fin = 1'b1;
                end else begin
                    n_widx  = r_widx + 8'd1;
                    lm_step = 1'b1;
                    n_state = ST_SFA;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res_value;
                    n_out_bad   = r_res_bad;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_value = fin_value;
                n_out_bad   = fin_bad;
                n_state     = ST_IDLE;
            end else begin
                n_res_value = fin_value;
                n_res_bad   = fin_bad;
                n_state     = ST_PUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_seed      <= n_seed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx      <= n_widx;
        r_first     <= n_first;
        r_mask      <= n_mask;
        r_limit     <= n_limit;
        r_bounded   <= n_bounded;
        r_out_value <= n_out_value;
        r_out_bad   <= n_out_bad;
        r_res_value <= n_res_value;
        r_res_bad   <= n_res_bad;
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r250_pkg::RING_LAST)
        else $error("ring pointer out of range");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ring_req.rd_en && ring_req.wr_en) |->
        (ring_req.rd_addr_a != ring_req.wr_addr &&
         ring_req.rd_addr_b != ring_req.wr_addr))
        else $error("ring read and write hit the same entry");

    a_writeback_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW) |-> (ring_req.wr_addr == $past(ring_req.rd_addr_a)))
        else $error("draw writes back to a word it did not read");

endmodule

`default_nettype wire
